/* sv/rmas_pkg.sv */
// shared types and constants for the row-major array store
`timescale 1ns / 1ps

package rmas_pkg;

    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 12;
    localparam int BOUND_W      = 13;
    localparam int NDIM_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int INDEX_FIELDS = 4;
    localparam int FIELD_SEL_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_3  = 3'd4;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_BEYOND    = 2'd2
    } status_t;

    typedef logic [BOUND_W-1:0] bound_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [NDIM_W-1:0]  ndim_t;

    // geometry view from the stride unit to the address pipe
    typedef struct packed {
        logic  busy;
        ndim_t dims;
    } geom_ctl_t;

    // access leaving the address pipe toward the memory
    typedef struct packed {
        logic    valid;
        logic    op;
        status_t status;
    } acc_ctl_t;

endpackage

/* sv/rmas_if.sv */
// handshake interfaces for the request, result and configuration channels
`timescale 1ns / 1ps

interface rmas_req_if import rmas_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [VALUE_W-1:0] write_value;
    index_t                    index_0;
    index_t                    index_1;
    index_t                    index_2;
    index_t                    index_3;

    modport source (output valid, op, write_value, index_0, index_1, index_2, index_3,
                    input ready);
    modport sink   (input valid, op, write_value, index_0, index_1, index_2, index_3,
                    output ready);
endinterface

interface rmas_rsp_if import rmas_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface rmas_cfg_if import rmas_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/rmas_mem.sv */
// element memory, one shared address, registered read data
`timescale 1ns / 1ps

module rmas_mem import rmas_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic               clk,
    input  logic               we,
    input  logic               re,
    input  logic [AW-1:0]      addr,
    input  logic [VALUE_W-1:0] wdata,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rmas_stride.sv */
// configuration registers and sequential row-major stride derivation
`timescale 1ns / 1ps

module rmas_stride import rmas_pkg::*; #(
    parameter int DIM_LIMIT   = 4,
    parameter int STORE_DEPTH = 4096,
    parameter int SW          = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bound_t                bounds [INDEX_FIELDS],
    output logic [SW-1:0]         strides [DIM_LIMIT],
    output geom_ctl_t             geom
);

    localparam int IW = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;
    localparam int PW = BOUND_W + SW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_START = 3'b010,
        S_STEP  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    ndim_t           num_dims_reg, num_dims_next;
    bound_t          bound_reg [INDEX_FIELDS];
    bound_t          bound_next [INDEX_FIELDS];
    logic [SW-1:0]   stride_reg [DIM_LIMIT];
    logic [SW-1:0]   stride_next [DIM_LIMIT];

    ndim_t           dims_used;
    logic [IW-1:0]   top_idx;
    bound_t          step_bound;
    logic [PW-1:0]   step_prod;
    logic [SW-1:0]   step_sat;

    always_comb
    begin
        priority if (num_dims_reg == ndim_t'(0))
        begin
            dims_used = ndim_t'(1);
        end
        else if (num_dims_reg > ndim_t'(DIM_LIMIT))
        begin
            dims_used = ndim_t'(DIM_LIMIT);
        end
        else
        begin
            dims_used = num_dims_reg;
        end
    end

    assign top_idx = IW'(dims_used - ndim_t'(1));

    // one multiply per step: stride[i-1] = bound[i] * stride[i], clipped at the depth
    assign step_bound = bound_reg[FIELD_SEL_W'(cnt_reg)];
    assign step_prod  = PW'(step_bound) * PW'(stride_reg[cnt_reg]);
    assign step_sat   = (step_prod > PW'(STORE_DEPTH)) ? SW'(STORE_DEPTH) : step_prod[SW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        num_dims_next = num_dims_reg;
        bound_next    = bound_reg;
        stride_next   = stride_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_START:
            begin
                for (int i = 0; i < DIM_LIMIT; i++)
                begin
                    stride_next[i] = '0;
                end
                stride_next[top_idx] = SW'(1);
                cnt_next             = top_idx;
                state_next           = (top_idx == IW'(0)) ? S_IDLE : S_STEP;
            end
            S_STEP:
            begin
                stride_next[cnt_reg - IW'(1)] = step_sat;
                cnt_next                      = cnt_reg - IW'(1);
                if (cnt_reg == IW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = S_START;
            if (cfg_index == REG_NUM_DIMS)
            begin
                num_dims_next = cfg_data[NDIM_W-1:0];
            end
            else if (cfg_index >= REG_BOUND_0 && cfg_index <= REG_BOUND_3)
            begin
                bound_next[FIELD_SEL_W'(cfg_index - REG_BOUND_0)] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            num_dims_reg <= ndim_t'(1);
            for (int i = 0; i < INDEX_FIELDS; i++)
            begin
                bound_reg[i] <= bound_t'(1);
            end
            for (int i = 0; i < DIM_LIMIT; i++)
            begin
                stride_reg[i] <= (i == 0) ? SW'(1) : '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            num_dims_reg <= num_dims_next;
            bound_reg    <= bound_next;
            stride_reg   <= stride_next;
        end
    end

    assign bounds    = bound_reg;
    assign strides   = stride_reg;
    assign geom.busy = (state_reg != S_IDLE);
    assign geom.dims = dims_used;

endmodule

/* sv/rmas_addr.sv */
// two-stage address pipe: bound check and stride products, then offset sum and range check
`timescale 1ns / 1ps

module rmas_addr import rmas_pkg::*; #(
    parameter int DIM_LIMIT   = 4,
    parameter int STORE_DEPTH = 4096,
    parameter int SW          = 13,
    parameter int AW          = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [VALUE_W-1:0] in_wval,
    input  index_t             in_idx [INDEX_FIELDS],
    input  bound_t             bounds [INDEX_FIELDS],
    input  logic [SW-1:0]      strides [DIM_LIMIT],
    input  geom_ctl_t          geom,
    input  logic               issue,
    output acc_ctl_t           acc,
    output logic [AW-1:0]      acc_offset,
    output logic [VALUE_W-1:0] acc_wval
);

    localparam int PW   = SW + INDEX_W;
    localparam int SUMW = PW + 2;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_op_reg;
    logic               s1_bad_reg;
    logic [VALUE_W-1:0] s1_wval_reg;
    logic [PW-1:0]      s1_prod_reg [DIM_LIMIT];

    logic               s2_valid_reg, s2_valid_next;
    logic               s2_op_reg;
    status_t            s2_status_reg;
    logic [AW-1:0]      s2_offset_reg;
    logic [VALUE_W-1:0] s2_wval_reg;

    logic               s1_en, s2_en, take, s1_move;
    logic               bad_in;
    logic [PW-1:0]      prod_in [DIM_LIMIT];
    logic [SUMW-1:0]    sum;
    status_t            status_in;

    assign s2_en    = !s2_valid_reg || issue;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en && !geom.busy;
    assign take     = in_valid && in_ready;
    assign s1_move  = s1_valid_reg && s2_en;

    // unused dimensions carry a zero stride, so only the check needs the mask
    always_comb
    begin
        bad_in = 1'b0;
        for (int i = 0; i < DIM_LIMIT; i++)
        begin
            prod_in[i] = PW'(strides[i]) * PW'(in_idx[i]);
            if (ndim_t'(i) < geom.dims && {1'b0, in_idx[i]} >= bounds[i])
            begin
                bad_in = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < DIM_LIMIT; i++)
        begin
            sum = sum + SUMW'(s1_prod_reg[i]);
        end
        priority if (s1_bad_reg)
        begin
            status_in = ST_BAD_INDEX;
        end
        else if (sum >= SUMW'(STORE_DEPTH))
        begin
            status_in = ST_BEYOND;
        end
        else
        begin
            status_in = ST_OK;
        end
    end

    assign s1_valid_next = take ? 1'b1 : (s2_en ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_move ? 1'b1 : (issue ? 1'b0 : s2_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg   <= in_op;
            s1_bad_reg  <= bad_in;
            s1_wval_reg <= in_wval;
            s1_prod_reg <= prod_in;
        end
        if (s1_move)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_status_reg <= status_in;
            s2_offset_reg <= sum[AW-1:0];
            s2_wval_reg   <= s1_wval_reg;
        end
    end

    assign acc.valid  = s2_valid_reg;
    assign acc.op     = s2_op_reg;
    assign acc.status = s2_status_reg;
    assign acc_offset = s2_offset_reg;
    assign acc_wval   = s2_wval_reg;

endmodule

/* sv/row_major_array_store.sv */
// row-major multi-dimensional array store, top level
//
//   channel  dir  beat contents
//   req      in   op, write_value, index_0..index_3
//   rsp      out  read_value, status
//   cfg      in   index (0 num_dims, 1..4 bound_0..bound_3), data
//
// an item passes bound check and stride multiplies, offset add and range compare,
// then the single memory port access, on its way from req beat to rsp valid.
// the pipe takes one item per cycle while rsp keeps draining and no stride pass runs.
// a cfg beat starts a stride pass of a start step plus one multiply per extra
// dimension; req.ready stays low during it.
// reset sets one dimension with all bounds at 1; element memory is undefined.
// rsp backpressure holds the result register and stalls the pipe back to req.
`timescale 1ns / 1ps

module row_major_array_store import rmas_pkg::*; #(
    parameter int MAX_DIMS    = 4,
    parameter int STORE_DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    rmas_req_if.sink   req,
    rmas_rsp_if.source rsp,
    rmas_cfg_if.sink   cfg
);

    localparam int DIM_LIMIT = (MAX_DIMS < INDEX_FIELDS) ? MAX_DIMS : INDEX_FIELDS;
    localparam int SW        = $clog2(STORE_DEPTH + 1);
    localparam int AW        = $clog2(STORE_DEPTH);

    bound_t             bounds [INDEX_FIELDS];
    logic [SW-1:0]      strides [DIM_LIMIT];
    geom_ctl_t          geom;
    index_t             req_idx [INDEX_FIELDS];

    acc_ctl_t           acc;
    logic [AW-1:0]      acc_offset;
    logic [VALUE_W-1:0] acc_wval;
    logic               issue, mem_we, mem_re;
    logic [VALUE_W-1:0] mem_rdata;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic               out_rd_ok_reg;

    assign cfg.ready = 1'b1;

    assign req_idx[0] = req.index_0;
    assign req_idx[1] = req.index_1;
    assign req_idx[2] = req.index_2;
    assign req_idx[3] = req.index_3;

    rmas_stride #(
        .DIM_LIMIT   (DIM_LIMIT),
        .STORE_DEPTH (STORE_DEPTH),
        .SW          (SW)
    ) u_stride (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .bounds    (bounds),
        .strides   (strides),
        .geom      (geom)
    );

    rmas_addr #(
        .DIM_LIMIT   (DIM_LIMIT),
        .STORE_DEPTH (STORE_DEPTH),
        .SW          (SW),
        .AW          (AW)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_op      (req.op),
        .in_wval    (req.write_value),
        .in_idx     (req_idx),
        .bounds     (bounds),
        .strides    (strides),
        .geom       (geom),
        .issue      (issue),
        .acc        (acc),
        .acc_offset (acc_offset),
        .acc_wval   (acc_wval)
    );

    // accesses issue one at a time in order, so a read always sees earlier writes
    assign issue  = acc.valid && (!out_valid_reg || rsp.ready);
    assign mem_we = issue && (acc.status == ST_OK) && (acc.op == OP_WRITE);
    assign mem_re = issue && (acc.status == ST_OK) && (acc.op == OP_READ);

    rmas_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (acc_offset),
        .wdata (acc_wval),
        .rdata (mem_rdata)
    );

    assign out_valid_next = issue ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_status_reg <= acc.status;
            out_rd_ok_reg  <= mem_re;
        end
    end

    // read data register only loads on a read, so it holds through a stall
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_rd_ok_reg ? mem_rdata : '0;

    a_cfg_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> !req.ready)
        else $error("request taken right after a configuration beat");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (out_valid_reg && out_rd_ok_reg))
        else $error("memory read not presented as a result");

    a_acc_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (acc.valid && !issue) |=> acc.valid)
        else $error("stalled access dropped");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> !out_rd_ok_reg)
        else $error("error result carries read data");

endmodule
